/* src/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants for row_softmax
// Widths, exponential table and the command and status groups that pass
// between controller and datapath.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int MAX_ROW         = 64;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int SCORE_W  = 16;
  localparam int PROB_W   = 16;
  localparam int CFG_W    = 7;
  localparam int SUM_W    = 23;
  localparam int ADDR_W   = $clog2(MAX_ROW);
  localparam int CNT_W    = $clog2(MAX_ROW + 1);
  localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH);
  localparam int DIFF_W   = 12;
  localparam int SCALE_W  = DIFF_W + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int QUOT_W   = PROB_W + 1;
  localparam int NUM_W    = PROB_W + QUOT_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  localparam int DIFF_LIMIT = 4096;

  localparam logic [SCORE_W-1:0] SCORE_MIN        = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]   ROW_LENGTH_RESET = CFG_W'(64);

  // Q2.62 arithmetic for building the exponential table at elaboration
  localparam logic [63:0] EXP_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] EXP_HALF = 64'h0000_2000_0000_0000;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  localparam logic [63:0] EXP_STEP = (EXP_ONE / 64'(EXP_TABLE_DEPTH)) * 64'd16;

  // Taylor terms of exp(-step)
  localparam logic [63:0] EXP_T1  = mul_q62(EXP_ONE, EXP_STEP) / 64'd1;
  localparam logic [63:0] EXP_T2  = mul_q62(EXP_T1,  EXP_STEP) / 64'd2;
  localparam logic [63:0] EXP_T3  = mul_q62(EXP_T2,  EXP_STEP) / 64'd3;
  localparam logic [63:0] EXP_T4  = mul_q62(EXP_T3,  EXP_STEP) / 64'd4;
  localparam logic [63:0] EXP_T5  = mul_q62(EXP_T4,  EXP_STEP) / 64'd5;
  localparam logic [63:0] EXP_T6  = mul_q62(EXP_T5,  EXP_STEP) / 64'd6;
  localparam logic [63:0] EXP_T7  = mul_q62(EXP_T6,  EXP_STEP) / 64'd7;
  localparam logic [63:0] EXP_T8  = mul_q62(EXP_T7,  EXP_STEP) / 64'd8;
  localparam logic [63:0] EXP_T9  = mul_q62(EXP_T8,  EXP_STEP) / 64'd9;
  localparam logic [63:0] EXP_T10 = mul_q62(EXP_T9,  EXP_STEP) / 64'd10;
  localparam logic [63:0] EXP_T11 = mul_q62(EXP_T10, EXP_STEP) / 64'd11;
  localparam logic [63:0] EXP_T12 = mul_q62(EXP_T11, EXP_STEP) / 64'd12;
  localparam logic [63:0] EXP_T13 = mul_q62(EXP_T12, EXP_STEP) / 64'd13;
  localparam logic [63:0] EXP_T14 = mul_q62(EXP_T13, EXP_STEP) / 64'd14;
  localparam logic [63:0] EXP_T15 = mul_q62(EXP_T14, EXP_STEP) / 64'd15;
  localparam logic [63:0] EXP_T16 = mul_q62(EXP_T15, EXP_STEP) / 64'd16;
  localparam logic [63:0] EXP_T17 = mul_q62(EXP_T16, EXP_STEP) / 64'd17;
  localparam logic [63:0] EXP_T18 = mul_q62(EXP_T17, EXP_STEP) / 64'd18;
  localparam logic [63:0] EXP_T19 = mul_q62(EXP_T18, EXP_STEP) / 64'd19;
  localparam logic [63:0] EXP_T20 = mul_q62(EXP_T19, EXP_STEP) / 64'd20;

  localparam logic [63:0] EXP_R = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13 + EXP_T14
                                - EXP_T15 + EXP_T16 - EXP_T17 + EXP_T18 - EXP_T19
                                + EXP_T20;

  function automatic logic [EXP_TABLE_DEPTH*PROB_W-1:0] build_exp_table();
    logic [EXP_TABLE_DEPTH*PROB_W-1:0] tbl;
    logic [63:0] p;
    logic [63:0] q;
    tbl = '0;
    p   = EXP_ONE;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      q = (p + EXP_HALF) >> 46;
      tbl[i*PROB_W +: PROB_W] = (q > 64'd65535) ? {PROB_W{1'b1}} : q[PROB_W-1:0];
      p = mul_q62(p, EXP_R);
    end
    return tbl;
  endfunction

  // exp(-k * 16 / depth) in unsigned Q0.16, entry k at bits [k*16 +: 16]
  localparam logic [EXP_TABLE_DEPTH*PROB_W-1:0] EXP_TABLE = build_exp_table();

  typedef struct packed {
    logic              accept;
    logic              rd_en;
    logic              sum_pass;
    logic [ADDR_W-1:0] rd_addr;
    logic              div_start;
    logic              row_clear;
  } rsm_cmd_t;

  typedef struct packed {
    logic row_full;
    logic idx_last;
    logic sum_busy;
    logic div_done;
  } rsm_status_t;

endpackage

/* src/rsm_div.sv */
// ----------------------------------------------------------------------------
// rsm_div: rounded restoring divider
// Computes round(e * 65536 / den) one quotient bit per cycle, saturated
// to 16 bits; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module rsm_div
  import rsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROB_W-1:0] e,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output logic [PROB_W-1:0] quot
);

  logic [SUM_W-1:0]     rem_r;
  logic [QUOT_W-1:0]    num_r;
  logic [SUM_W-1:0]     den_r;
  logic                 zero_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] step_r;

  logic [NUM_W-1:0]     numer;
  logic [SUM_W:0]       shifted;
  logic [SUM_W:0]       trial;
  logic                 fits;
  logic [SUM_W-1:0]     rem_nxt;
  logic                 last_step;

  // Quotient stays below 2^17, so the top bits of the numerator start below den
  assign numer     = NUM_W'({e, PROB_W'(0)}) + NUM_W'(den >> 1);
  assign shifted   = {rem_r, num_r[QUOT_W-1]};
  assign trial     = shifted - {1'b0, den_r};
  assign fits      = ~trial[SUM_W];
  assign rem_nxt   = fits ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
  assign last_step = (step_r == DIV_CNT_W'(QUOT_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r & last_step;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (last_step) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= SUM_W'(numer[NUM_W-1:QUOT_W]);
      num_r  <= numer[QUOT_W-1:0];
      den_r  <= den;
      zero_r <= (den == '0);
    end else if (run_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[QUOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 :
                num_r[QUOT_W-1] ? {PROB_W{1'b1}} : num_r[PROB_W-1:0];

endmodule

/* src/rsm_datapath.sv */
// ----------------------------------------------------------------------------
// rsm_datapath: row buffer, maximum, exponential lookup and sum
// Holds the row length register, the score memory, the running maximum,
// the exponential sum, the divider and the result registers.
// ----------------------------------------------------------------------------
module rsm_datapath
  import rsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rsm_cmd_t           cmd,
  input  logic [SCORE_W-1:0] in_score,
  input  logic               cfg_valid,
  input  logic [CFG_W-1:0]   cfg_row_length,
  output rsm_status_t        status,
  output logic               out_valid,
  output logic [PROB_W-1:0]  out_probability,
  output logic               out_last
);

  logic [SCORE_W-1:0] mem [MAX_ROW];

  logic [CFG_W-1:0]   len_r;
  logic [CNT_W-1:0]   count_r;
  logic [SCORE_W-1:0] max_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SCORE_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [PROB_W-1:0]  e_r;
  logic               e_vld_r;
  logic               out_valid_r;
  logic [PROB_W-1:0]  out_prob_r;
  logic               out_last_r;

  logic [CNT_W-1:0]   len_eff;
  logic [CNT_W-1:0]   count_inc;
  logic [SCORE_W:0]   diff;
  logic [SCALE_W-1:0] scaled;
  logic [IDX_W-1:0]   tbl_idx;
  logic [PROB_W-1:0]  e_lookup;
  logic               div_done;
  logic [PROB_W-1:0]  div_quot;

  always_comb begin
    priority if (len_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_r > CFG_W'(MAX_ROW)) begin
      len_eff = CNT_W'(MAX_ROW);
    end else begin
      len_eff = CNT_W'(len_r);
    end
  end

  assign count_inc = count_r + 1'b1;

  // Difference to the row maximum, in Q8.8 units
  assign diff    = {max_r[SCORE_W-1], max_r} - {rd_data_r[SCORE_W-1], rd_data_r};
  assign scaled  = SCALE_W'(diff[DIFF_W-1:0]) * SCALE_W'(EXP_TABLE_DEPTH);
  assign tbl_idx = scaled[DIFF_W +: IDX_W];

  always_comb begin
    priority if (diff[SCORE_W]) begin
      e_lookup = EXP_TABLE[0 +: PROB_W];
    end else if (diff >= (SCORE_W+1)'(DIFF_LIMIT)) begin
      e_lookup = '0;
    end else begin
      e_lookup = EXP_TABLE[tbl_idx*PROB_W +: PROB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[count_r[ADDR_W-1:0]] <= in_score;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_lookup;
    if (div_done) begin
      out_prob_r <= div_quot;
      out_last_r <= status.idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= ROW_LENGTH_RESET;
      count_r     <= '0;
      max_r       <= SCORE_MIN;
      sum_r       <= '0;
      rd_vld_r    <= 1'b0;
      e_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_row_length;
      end
      rd_vld_r    <= cmd.rd_en & cmd.sum_pass;
      e_vld_r     <= rd_vld_r;
      out_valid_r <= div_done;
      if (cmd.row_clear) begin
        count_r <= '0;
        max_r   <= SCORE_MIN;
        sum_r   <= '0;
      end else begin
        if (cmd.accept) begin
          count_r <= count_inc;
          if ($signed(in_score) > $signed(max_r)) begin
            max_r <= in_score;
          end
        end
        if (e_vld_r) begin
          sum_r <= sum_r + SUM_W'(e_r);
        end
      end
    end
  end

  rsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .e     (e_r),
    .den   (sum_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign status.row_full = (count_inc >= len_eff);
  assign status.idx_last = ((CNT_W'(cmd.rd_addr) + 1'b1) == count_r);
  assign status.sum_busy = rd_vld_r | e_vld_r;
  assign status.div_done = div_done;

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_last        = out_last_r;

endmodule

/* src/rsm_ctrl.sv */
// ----------------------------------------------------------------------------
// rsm_ctrl: row sequencer
// Takes scores while idle, then runs the sum pass over the row and the
// divide pass, one element at a time.
// ----------------------------------------------------------------------------
module rsm_ctrl
  import rsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  rsm_status_t status,
  output rsm_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_DIV_RD,
    S_DIV_WAIT,
    S_DIV_GO,
    S_DIV_RUN
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] idx_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept && status.row_full) begin
            state_r <= S_SUM;
            idx_r   <= '0;
            busy_r  <= 1'b1;
          end
        end
        S_SUM: begin
          if (status.idx_last) begin
            idx_r   <= '0;
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // hold until the last exponential has landed in the sum
          if (!status.sum_busy) begin
            state_r <= S_DIV_RD;
          end
        end
        S_DIV_RD:   state_r <= S_DIV_WAIT;
        S_DIV_WAIT: state_r <= S_DIV_GO;
        S_DIV_GO:   state_r <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (status.div_done) begin
            if (status.idx_last) begin
              idx_r   <= '0;
              busy_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_DIV_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = idx_r;
    cmd.accept  = start & ~busy_r;
    unique case (state_r)
      S_SUM: begin
        cmd.rd_en    = 1'b1;
        cmd.sum_pass = 1'b1;
      end
      S_DIV_RD:  cmd.rd_en     = 1'b1;
      S_DIV_GO:  cmd.div_start = 1'b1;
      S_DIV_RUN: cmd.row_clear = status.div_done & status.idx_last;
      default:   cmd.rd_en     = 1'b0;
    endcase
  end

  assign busy = busy_r;

endmodule

/* src/row_softmax.sv */
// ----------------------------------------------------------------------------
// row_softmax: row-wise softmax over signed Q8.8 scores
// Buffers a row, subtracts its maximum, and emits one Q0.16 probability
// per element with the last one of the row flagged.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle while busy is low. On the score that
// completes a row, busy rises and stays high until the row's last result:
// the sum pass reads the row buffer once per element, then each element
// in turn goes through a buffer read, a table lookup and a 17-step
// bit-serial divider. Each result appears on out_probability and
// out_last for exactly one cycle with out_valid high and cannot be stalled.
// The row length register may be written at any time through cfg_valid;
// a new length applies at once, so a partly filled row that already holds
// that many scores closes on the next score.
module row_softmax
  import rsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [SCORE_W-1:0] in_score,
  output logic               out_valid,
  output logic [PROB_W-1:0]  out_probability,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_row_length
);

  rsm_cmd_t    cmd;
  rsm_status_t status;

  assign cfg_ready = 1'b1;

  rsm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rsm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_score        (in_score),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_row_length  (cfg_row_length),
    .status          (status),
    .out_valid       (out_valid),
    .out_probability (out_probability),
    .out_last        (out_last)
  );

  // busy only rises on an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // mid-row results come while busy, the last result once idle again
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_last))
    else $error("result strobe out of step with busy");

  // results are spaced by the divider, never back to back
  a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

endmodule
